// ----- rtl/core/tfdmd_pkg.sv -----
// Shared constants and types for the three-frame difference motion detector.
`timescale 1ns / 1ps

package tfdmd_pkg;

	localparam int MAX_PIXELS = 524288;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int TOTAL_W    = ADDR_W + 1;
	localparam int COUNT_W    = 20;
	localparam int LUMA_W     = 8;
	localparam int HIST_W     = 2 * LUMA_W;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 10;
	localparam int AREA_W     = WIDTH_W + HEIGHT_W;
	localparam int THR_W      = 8;
	localparam int RATIO_W    = 17;
	localparam int RATIO_FRAC = 16;
	localparam int PROD_W     = RATIO_W + TOTAL_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int MDATA_W    = 24;

	localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
	localparam logic [WIDTH_W-1:0]  WIDTH_RST    = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = HEIGHT_W'(480);
	localparam logic [THR_W-1:0]    THR_RST      = THR_W'(25);
	localparam logic [RATIO_W-1:0]  RATIO_RST    = RATIO_W'(6554);
	localparam logic [1:0]          WARM_FRAMES  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_DIFF_THR     = 2'd2,
		CFG_ALARM_RATIO  = 2'd3
	} cfg_idx_t;

	function automatic logic [LUMA_W-1:0] abs_diff(input logic [LUMA_W-1:0] a,
		input logic [LUMA_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ----- rtl/core/three_frame_difference_motion_detector.sv -----
// Three-frame difference motion detector: pixel history memory, motion count, frame alarm.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid/s_tready    s_tdata[7:0] luma
//   m_*       out  m_tvalid/m_tready    m_tdata[0] alarm, [20:1] motion_count; m_tuser warming_up
//   cfg_*     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One pixel per clock while s_tready is high; the history memory takes one read and one write per pixel.
// After its last pixel is taken, a frame result passes through stage 1, stage 2 and the output register.
// Reset clears counters and loads register defaults; history is filled by the two warm-up frames.
// Two frame results can wait; the input stalls only when a third frame end meets both held.
`timescale 1ns / 1ps

module three_frame_difference_motion_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tfdmd_pkg::LUMA_W-1:0]        s_tdata,   // [7:0] luma
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tfdmd_pkg::MDATA_W-1:0]       m_tdata,   // [0] alarm, [20:1] motion_count
	output logic                                m_tuser,   // [0] warming_up
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  tfdmd_pkg::cfg_idx_t                 cfg_index,
	input  logic [tfdmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tfdmd_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [THR_W-1:0]    thr_q;
	logic [RATIO_W-1:0]  ratio_q;

	logic [HIST_W-1:0]   hist_mem [MAX_PIXELS];

	logic [ADDR_W-1:0]   idx_q;
	logic [1:0]          frames_q;
	logic [COUNT_W-1:0]  mt_q;

	logic                valid_s1;
	logic [LUMA_W-1:0]   luma_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                end_s1;
	logic                warm_s1;
	logic [TOTAL_W-1:0]  total_s1;
	logic                fwd_s1;
	logic [HIST_W-1:0]   fwd_data_s1;
	logic [HIST_W-1:0]   rd_data_s1;

	logic                valid_s2;
	logic                warm_s2;
	logic [COUNT_W-1:0]  count_s2;
	logic [PROD_W-1:0]   prod_s2;

	logic                out_valid_q;
	logic                out_alarm_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_warm_q;

	logic [AREA_W-1:0]   area;
	logic [TOTAL_W-1:0]  total;
	logic [TOTAL_W-1:0]  idx_inc;
	logic                end_s0;
	logic                warm_s0;
	logic                accept;
	logic                s1_adv;
	logic                s2_adv;
	logic                wr_en;
	logic [HIST_W-1:0]   hist;
	logic [LUMA_W-1:0]   prev1;
	logic [LUMA_W-1:0]   prev2;
	logic                motion;
	logic [HIST_W-1:0]   wr_data;
	logic [COUNT_W-1:0]  mt_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thr_q    <= THR_RST;
			ratio_q  <= RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_FRAME_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_DIFF_THR:     thr_q    <= cfg_data[THR_W-1:0];
				CFG_ALARM_RATIO:  ratio_q  <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		area = AREA_W'(width_q) * AREA_W'(height_q);
		if (area == '0) begin
			total = TOTAL_W'(1);
		end else if (area > AREA_W'(MAX_PIXELS)) begin
			total = TOTAL_W'(MAX_PIXELS);
		end else begin
			total = area[TOTAL_W-1:0];
		end
		idx_inc = TOTAL_W'(idx_q) + TOTAL_W'(1);
		end_s0  = (idx_inc >= total);
		warm_s0 = (frames_q != WARM_FRAMES);
	end

	assign s2_adv   = !out_valid_q || m_tready;
	assign s1_adv   = !valid_s1 || !end_s1 || !valid_s2 || s2_adv;
	assign s_tready = s1_adv;
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = valid_s1 && s1_adv;

	always_comb begin
		hist    = fwd_s1 ? fwd_data_s1 : rd_data_s1;
		prev1   = hist[LUMA_W-1:0];
		prev2   = hist[HIST_W-1:LUMA_W];
		motion  = !warm_s1 && (abs_diff(prev2, prev1) > thr_q) &&
			(abs_diff(prev1, luma_s1) > thr_q);
		wr_data = {prev1, luma_s1};
		mt_next = (motion && (mt_q != COUNT_MAX)) ? (mt_q + COUNT_W'(1)) : mt_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[addr_s1] <= wr_data;
		end
		if (accept) begin
			rd_data_s1 <= hist_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			frames_q <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			idx_q    <= end_s0 ? '0 : idx_inc[ADDR_W-1:0];
			if (end_s0 && warm_s0) begin
				frames_q <= frames_q + 2'd1;
			end
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1     <= s_tdata;
			addr_s1     <= idx_q;
			end_s1      <= end_s0;
			warm_s1     <= warm_s0;
			total_s1    <= total;
			fwd_s1      <= wr_en && (addr_s1 == idx_q);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (wr_en) begin
				mt_q <= end_s1 ? '0 : mt_next;
			end
			if (wr_en && end_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && end_s1) begin
			warm_s2  <= warm_s1;
			count_s2 <= mt_next;
			prod_s2  <= PROD_W'(ratio_q) * PROD_W'(total_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && valid_s2) begin
			out_alarm_q <= !warm_s2 &&
				((PROD_W - RATIO_FRAC)'(count_s2) > prod_s2[PROD_W-1:RATIO_FRAC]);
			out_count_q <= warm_s2 ? '0 : count_s2;
			out_warm_q  <= warm_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(MDATA_W - COUNT_W - 1)'(0), out_count_q, out_alarm_q};
	assign m_tuser  = out_warm_q;

endmodule
